>>> rtl/core/fcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_pkg: shared types and constants of the fuzzy c-means membership block
// Item classes, register indexes, fixed-point widths and exp2 constants.
// ----------------------------------------------------------------------------
package fcm_pkg;

	typedef struct packed {
		logic wr;   // centroid coordinate write
		logic acc;  // feature that adds to the distances
		logic fin;  // last feature of a point: emit results
	} item_cls_t;

	localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
	localparam logic [1:0] REG_DIM_COUNT     = 2'd1;
	localparam logic [1:0] REG_EXPONENT      = 2'd2;

	localparam int DIST_W = 37;
	localparam int LOG_W  = 22;
	localparam int TERM_W = 32;
	localparam int MEM_W  = 17;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [MEM_W-1:0]  ONE_Q16  = 17'h10000;

	function automatic logic [63:0] isqrt64(input logic [63:0] xin);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = xin;
		r = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(2^-j) in Q30, by repeated truncating square roots
	function automatic logic [31:0] exp_const(input int j);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int i = 1; i <= j; i++) begin
			c = isqrt64(c << 30);
		end
		return c[31:0];
	endfunction

endpackage

>>> rtl/core/fcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/fcm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_front: input acceptance, classification and item queue
// Classifies each item and holds up to two items for the engine.
// ----------------------------------------------------------------------------
module fcm_front #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int MAX_DIMS      = 16,
	parameter int FEATURE_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_op,
	input  logic [2:0]               in_ci,
	input  logic [3:0]               in_fi,
	input  logic [FEATURE_WIDTH-1:0] in_value,
	input  logic                     in_last,
	input  logic [4:0]               dim_count,
	output logic                     q_valid,
	input  logic                     q_pop,
	output fcm_pkg::item_cls_t       q_cls,
	output logic [2:0]               q_ci,
	output logic [3:0]               q_fi,
	output logic [FEATURE_WIDTH-1:0] q_value
);

	fcm_pkg::item_cls_t       cls_q   [2];
	logic [2:0]               ci_q    [2];
	logic [3:0]               fi_q    [2];
	logic [FEATURE_WIDTH-1:0] value_q [2];
	logic                     wp_q;
	logic                     rp_q;
	logic [1:0]               count_q;
	fcm_pkg::item_cls_t       cls_in;
	logic                     push;
	logic                     fi_in_dims;

	assign fi_in_dims = ({1'b0, in_fi} < dim_count) && (32'(in_fi) < MAX_DIMS);

	always_comb begin
		cls_in.wr  = !in_op && (32'(in_ci) < MAX_CLUSTERS) && (32'(in_fi) < MAX_DIMS);
		cls_in.acc = in_op && fi_in_dims;
		cls_in.fin = in_op && in_last;
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_cls    = cls_q[rp_q];
	assign q_ci     = ci_q[rp_q];
	assign q_fi     = fi_q[rp_q];
	assign q_value  = value_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cls_q[wp_q]   <= cls_in;
			ci_q[wp_q]    <= in_ci;
			fi_q[wp_q]    <= in_fi;
			value_q[wp_q] <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (q_pop && q_valid) begin
				rp_q <= !rp_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

endmodule

>>> rtl/core/fcm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcm_back: distance accumulation and membership engine
// Runs one item at a time: distance passes, log2, pairwise exp2, division.
// ----------------------------------------------------------------------------
module fcm_back #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int MAX_DIMS      = 16,
	parameter int FEATURE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_valid,
	output logic                                    q_pop,
	input  fcm_pkg::item_cls_t                      q_cls,
	input  logic [2:0]                              q_ci,
	input  logic [3:0]                              q_fi,
	input  logic [FEATURE_WIDTH-1:0]                q_value,
	input  logic [$clog2(MAX_CLUSTERS)-1:0]         kc_m1,
	input  logic [15:0]                             exponent,
	output logic                                    ram_we,
	output logic [$clog2(MAX_CLUSTERS*MAX_DIMS)-1:0] ram_waddr,
	output logic [FEATURE_WIDTH-1:0]                ram_wdata,
	output logic [$clog2(MAX_CLUSTERS*MAX_DIMS)-1:0] ram_raddr,
	input  logic [FEATURE_WIDTH-1:0]                ram_rdata,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [2:0]                              out_cluster,
	output logic [fcm_pkg::MEM_W-1:0]               out_membership,
	output logic [fcm_pkg::DIST_W-1:0]              out_distance,
	output logic                                    out_last
);

	localparam int IW     = $clog2(MAX_CLUSTERS);
	localparam int AW     = $clog2(MAX_CLUSTERS * MAX_DIMS);
	localparam int FW     = FEATURE_WIDTH;
	localparam int DW     = fcm_pkg::DIST_W;
	localparam int LW     = fcm_pkg::LOG_W;
	localparam int TW     = fcm_pkg::TERM_W;
	localparam int SQ_W   = 2 * FW + 2;
	localparam int ADD_W  = ((SQ_W > DW) ? SQ_W : DW) + 1;
	localparam int SUM_W  = TW + IW + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FRD   = 4'd1;
	localparam logic [3:0] S_FMUL  = 4'd2;
	localparam logic [3:0] S_FACC  = 4'd3;
	localparam logic [3:0] S_LLOAD = 4'd4;
	localparam logic [3:0] S_LNORM = 4'd5;
	localparam logic [3:0] S_LSQ   = 4'd6;
	localparam logic [3:0] S_ROW   = 4'd7;
	localparam logic [3:0] S_PAIR  = 4'd8;
	localparam logic [3:0] S_PMUL  = 4'd9;
	localparam logic [3:0] S_EXP   = 4'd10;
	localparam logic [3:0] S_EFIN  = 4'd11;
	localparam logic [3:0] S_ADD   = 4'd12;
	localparam logic [3:0] S_DIV   = 4'd13;
	localparam logic [3:0] S_EMIT  = 4'd14;

	localparam logic [31:0] EXP_C [16] = '{
		fcm_pkg::exp_const(1),  fcm_pkg::exp_const(2),  fcm_pkg::exp_const(3),
		fcm_pkg::exp_const(4),  fcm_pkg::exp_const(5),  fcm_pkg::exp_const(6),
		fcm_pkg::exp_const(7),  fcm_pkg::exp_const(8),  fcm_pkg::exp_const(9),
		fcm_pkg::exp_const(10), fcm_pkg::exp_const(11), fcm_pkg::exp_const(12),
		fcm_pkg::exp_const(13), fcm_pkg::exp_const(14), fcm_pkg::exp_const(15),
		fcm_pkg::exp_const(16)
	};

	logic [3:0]              state_q;
	logic                    fin_q;
	logic [3:0]              fi_q;
	logic [FW-1:0]           val_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           idx2_q;
	logic [DW-1:0]           acc_q [MAX_CLUSTERS];
	logic [LW-1:0]           log_q [MAX_CLUSTERS];
	logic [SQ_W-1:0]         sq_q;
	logic [DW-1:0]           n_q;
	logic [5:0]              p_q;
	logic [31:0]             m_q;
	logic [15:0]             frac_q;
	logic [3:0]              cnt_q;
	logic [DW-1:0]           dk_q;
	logic [LW-1:0]           lk_q;
	logic signed [39:0]      prod_q;
	logic signed [11:0]      ip_q;
	logic [15:0]             f_q;
	logic [31:0]             r_q;
	logic [TW-1:0]           term_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SUM_W-1:0]        rem_q;
	logic [32:0]             quo_q;
	logic [5:0]              dcnt_q;
	logic                    out_valid_q;
	logic [2:0]              out_cluster_q;
	logic [fcm_pkg::MEM_W-1:0] out_mem_q;
	logic [DW-1:0]           out_dist_q;
	logic                    out_last_q;

	logic [IW-1:0]           rd_idx;
	logic [DW-1:0]           rd_acc;
	logic [LW-1:0]           rd_log;
	logic signed [FW:0]      fdiff;
	logic [FW:0]             fabs;
	logic [ADD_W-1:0]        acc_sum;
	logic [63:0]             msq;
	logic [31:0]             m2;
	logic [15:0]             frac_next;
	logic signed [LW:0]      ldiff;
	logic signed [39:0]      y;
	logic [63:0]             rc;
	logic [33:0]             r_up;
	logic signed [11:0]      s_dn;
	logic [TW-1:0]           term_fin;
	logic [SUM_W:0]          rem_sh;
	logic                    rem_ge;
	logic [fcm_pkg::MEM_W-1:0] mem_val;
	logic                    emit_ok;

	assign rd_idx = (state_q == S_PAIR) ? idx2_q : idx_q;
	assign rd_acc = acc_q[rd_idx];
	assign rd_log = log_q[rd_idx];

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign ram_we    = q_pop && q_cls.wr;
	assign ram_waddr = AW'(int'(q_ci) * MAX_DIMS + int'(q_fi));
	assign ram_wdata = q_value;
	assign ram_raddr = AW'(int'(idx_q) * MAX_DIMS + int'(fi_q));

	always_comb begin
		fdiff     = $signed({val_q[FW-1], val_q}) - $signed({ram_rdata[FW-1], ram_rdata});
		fabs      = fdiff[FW] ? (~fdiff + 1'b1) : fdiff;
		acc_sum   = ADD_W'(acc_q[idx_q]) + ADD_W'(sq_q);
		msq       = m_q * m_q;
		m2        = msq[61:30];
		frac_next = frac_q | (m2[31] ? (16'd1 << cnt_q) : 16'd0);
		ldiff     = $signed({1'b0, lk_q}) - $signed({1'b0, rd_log});
		y         = prod_q >>> 12;
		rc        = r_q * EXP_C[cnt_q];
		r_up      = 34'(r_q) << (2'(ip_q - 12'sd14));
		s_dn      = 12'sd14 - ip_q;
		if (ip_q > 12'sd16) begin
			term_fin = '1;
		end else if (ip_q >= 12'sd14) begin
			term_fin = (r_up[33:32] != 2'd0) ? '1 : r_up[31:0];
		end else if (s_dn >= 12'sd31) begin
			term_fin = '0;
		end else begin
			term_fin = r_q >> s_dn[4:0];
		end
		rem_sh  = {rem_q, (dcnt_q == 6'd32)};
		rem_ge  = rem_sh >= {1'b0, sum_q};
		if (sum_q == '0) begin
			mem_val = '0;
		end else if (quo_q > 33'(fcm_pkg::ONE_Q16)) begin
			mem_val = fcm_pkg::ONE_Q16;
		end else begin
			mem_val = quo_q[fcm_pkg::MEM_W-1:0];
		end
		emit_ok = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					fin_q <= q_cls.fin;
					fi_q  <= q_fi;
					val_q <= q_value;
				end
			end
			S_FMUL: begin
				sq_q <= SQ_W'(fabs * fabs);
			end
			S_LLOAD: begin
				n_q <= rd_acc;
				p_q <= 6'd36;
			end
			S_LNORM: begin
				if (n_q[DW-1]) begin
					m_q    <= {1'b0, n_q[DW-1:DW-31]};
					frac_q <= '0;
				end else begin
					n_q <= n_q << 1;
					p_q <= p_q - 6'd1;
				end
			end
			S_LSQ: begin
				m_q    <= m2[31] ? {1'b0, m2[31:1]} : m2;
				frac_q <= frac_next;
			end
			S_ROW: begin
				dk_q  <= rd_acc;
				lk_q  <= rd_log;
				sum_q <= '0;
			end
			S_PAIR: begin
				if (rd_acc == '0) begin
					term_q <= '0;
				end else if (dk_q == '0) begin
					term_q <= (exponent == 16'd0) ? TW'(fcm_pkg::ONE_Q16) : '0;
				end else begin
					prod_q <= 40'(ldiff) * $signed({24'd0, exponent});
				end
			end
			S_PMUL: begin
				ip_q <= y[27:16];
				f_q  <= y[15:0];
				r_q  <= 32'd1 << 30;
			end
			S_EXP: begin
				if (f_q[4'd15 - cnt_q]) begin
					r_q <= rc[61:30];
				end
			end
			S_EFIN: begin
				term_q <= term_fin;
			end
			S_ADD: begin
				sum_q <= sum_q + SUM_W'(term_q);
				rem_q <= '0;
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= rem_ge ? SUM_W'(rem_sh - {1'b0, sum_q}) : rem_sh[SUM_W-1:0];
				quo_q <= {quo_q[31:0], rem_ge};
			end
			default: begin
			end
		endcase
		if (state_q == S_EMIT && emit_ok) begin
			out_cluster_q <= 3'(idx_q);
			out_mem_q     <= mem_val;
			out_dist_q    <= dk_q;
			out_last_q    <= (idx_q == kc_m1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			idx2_q      <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				acc_q[i] <= '0;
				log_q[i] <= '0;
			end
		end else begin
			if (state_q == S_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (q_pop) begin
						if (q_cls.acc) begin
							state_q <= S_FRD;
						end else if (q_cls.fin) begin
							state_q <= S_LLOAD;
						end
					end
				end
				S_FRD: state_q <= S_FMUL;
				S_FMUL: state_q <= S_FACC;
				S_FACC: begin
					acc_q[idx_q] <= (acc_sum > ADD_W'(fcm_pkg::DIST_MAX)) ?
						fcm_pkg::DIST_MAX : acc_sum[DW-1:0];
					if (idx_q == kc_m1) begin
						idx_q   <= '0;
						state_q <= fin_q ? S_LLOAD : S_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_LLOAD: begin
					if (rd_acc == '0) begin
						log_q[idx_q] <= '0;
						if (idx_q == kc_m1) begin
							idx_q   <= '0;
							state_q <= S_ROW;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						state_q <= S_LNORM;
					end
				end
				S_LNORM: begin
					if (n_q[DW-1]) begin
						cnt_q   <= 4'd15;
						state_q <= S_LSQ;
					end
				end
				S_LSQ: begin
					if (cnt_q == 4'd0) begin
						log_q[idx_q] <= {p_q, frac_next};
						if (idx_q == kc_m1) begin
							idx_q   <= '0;
							state_q <= S_ROW;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_LLOAD;
						end
					end else begin
						cnt_q <= cnt_q - 4'd1;
					end
				end
				S_ROW: begin
					idx2_q  <= '0;
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					state_q <= (rd_acc == '0 || dk_q == '0) ? S_ADD : S_PMUL;
				end
				S_PMUL: begin
					cnt_q   <= 4'd0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					if (cnt_q == 4'd15) begin
						state_q <= S_EFIN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_EFIN: state_q <= S_ADD;
				S_ADD: begin
					if (idx2_q == kc_m1) begin
						dcnt_q  <= 6'd32;
						state_q <= S_DIV;
					end else begin
						idx2_q  <= idx2_q + 1'b1;
						state_q <= S_PAIR;
					end
				end
				S_DIV: begin
					if (dcnt_q == 6'd0) begin
						state_q <= S_EMIT;
					end else begin
						dcnt_q <= dcnt_q - 6'd1;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						if (idx_q == kc_m1) begin
							for (int i = 0; i < MAX_CLUSTERS; i++) begin
								acc_q[i] <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_ROW;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_cluster    = out_cluster_q;
	assign out_membership = out_mem_q;
	assign out_distance   = out_dist_q;
	assign out_last       = out_last_q;

endmodule

>>> rtl/core/fuzzy_cmeans_membership.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_cmeans_membership: fuzzy c-means membership update
// Centroid table, streamed squared distances, Q16 membership per cluster.
// ----------------------------------------------------------------------------
// Usage:
//  Input items arrive on s_t*: tuser=0 writes one centroid coordinate,
//  tuser=1 streams one feature of a point; tlast on a feature ends the point.
//  At the end of a point one result item per active cluster leaves on m_t*,
//  in cluster order, with tlast on the last cluster.
//  Work per item: a coordinate write is a single RAM write; a feature runs,
//  per active cluster, a centroid RAM read, a square and a saturating add.
//  The end of a point runs per cluster a log2 (normalize shift plus 16
//  squaring steps on the 31x31 multiplier), then per cluster pair an exp2
//  (16 multiply steps) and per cluster a bit-serial division.
//  A two-item queue accepts input items until full while the engine works.
//  Results sit in an output register; a stalled receiver holds the engine
//  at the next result while the queue keeps filling.
//  Reset clears accumulators, presets registers; the centroid table is
//  undefined until written. Registers go through cfg_we/cfg_index/cfg_data
//  while the block is idle.
// ----------------------------------------------------------------------------
module fuzzy_cmeans_membership #(
	parameter int MAX_CLUSTERS  = 8,
	parameter int MAX_DIMS      = 16,
	parameter int FEATURE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cluster_index[2:0], feature_index[6:3], value, zero fill
	input  logic [((FEATURE_WIDTH + 14) / 8) * 8 - 1:0] s_tdata,
	// operation
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cluster[2:0], membership[19:3], squared_distance[56:20], zero fill
	output logic [63:0] m_tdata,
	output logic        m_tlast
);

	localparam int IW = $clog2(MAX_CLUSTERS);
	localparam int AW = $clog2(MAX_CLUSTERS * MAX_DIMS);
	localparam int FW = FEATURE_WIDTH;

	logic [3:0]  cluster_count_q;
	logic [4:0]  dim_count_q;
	logic [15:0] exponent_q;
	logic [IW-1:0] kc_m1;

	logic                 q_valid;
	logic                 q_pop;
	fcm_pkg::item_cls_t   q_cls;
	logic [2:0]           q_ci;
	logic [3:0]           q_fi;
	logic [FW-1:0]        q_value;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [FW-1:0]        ram_wdata;
	logic [AW-1:0]        ram_raddr;
	logic [FW-1:0]        ram_rdata;
	logic [2:0]           o_cluster;
	logic [fcm_pkg::MEM_W-1:0]  o_mem;
	logic [fcm_pkg::DIST_W-1:0] o_dist;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= 4'd2;
			dim_count_q     <= 5'd1;
			exponent_q      <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				fcm_pkg::REG_CLUSTER_COUNT: cluster_count_q <= cfg_data[3:0];
				fcm_pkg::REG_DIM_COUNT:     dim_count_q     <= cfg_data[4:0];
				fcm_pkg::REG_EXPONENT:      exponent_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// zero acts as one cluster, large counts clamp to the table size
	always_comb begin
		if (cluster_count_q == 4'd0) begin
			kc_m1 = '0;
		end else if (32'(cluster_count_q) > MAX_CLUSTERS) begin
			kc_m1 = IW'(MAX_CLUSTERS - 1);
		end else begin
			kc_m1 = IW'(cluster_count_q - 4'd1);
		end
	end

	fcm_front #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_DIMS(MAX_DIMS),
		.FEATURE_WIDTH(FEATURE_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op(s_tuser),
		.in_ci(s_tdata[2:0]),
		.in_fi(s_tdata[6:3]),
		.in_value(s_tdata[FW+6:7]),
		.in_last(s_tlast),
		.dim_count(dim_count_q),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_cls(q_cls),
		.q_ci(q_ci),
		.q_fi(q_fi),
		.q_value(q_value)
	);

	fcm_ram #(
		.WIDTH(FW),
		.DEPTH(MAX_CLUSTERS * MAX_DIMS)
	) u_centroids (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fcm_back #(
		.MAX_CLUSTERS(MAX_CLUSTERS),
		.MAX_DIMS(MAX_DIMS),
		.FEATURE_WIDTH(FEATURE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_cls(q_cls),
		.q_ci(q_ci),
		.q_fi(q_fi),
		.q_value(q_value),
		.kc_m1(kc_m1),
		.exponent(exponent_q),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_cluster(o_cluster),
		.out_membership(o_mem),
		.out_distance(o_dist),
		.out_last(m_tlast)
	);

	assign m_tdata = {7'd0, o_dist, o_mem, o_cluster};

endmodule

>>> sim/fuzzy_cmeans_membership_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_cmeans_membership_tb: self-checking bench for the membership block
// Fills the centroid table, then streams points under several register
// settings with random bursts and output stalls. Each result is checked
// field by field against a fixed-point membership predictor.
// ----------------------------------------------------------------------------
module fuzzy_cmeans_membership_tb;

	typedef longint unsigned u64_t;

	localparam int NCL = 8;
	localparam int NDIM = 16;
	localparam int IDLE_LIMIT = 50000;
	localparam logic OP_CENTROID = 1'b0;
	localparam logic OP_FEATURE  = 1'b1;
	localparam u64_t TERM_SAT = 64'hFFFF_FFFF;
	localparam u64_t Q30_ONE = 64'd1 << 30;

	typedef struct {
		logic               op;
		logic [2:0]         ci;
		logic [3:0]         fi;
		logic signed [15:0] val;
		logic               last;
	} fcm_item_t;

	typedef struct {
		logic [2:0]  cl;
		logic [16:0] memb;
		logic [36:0] sqd;
		logic        last;
	} memb_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// cluster_index[2:0], feature_index[6:3], value[22:7], zero fill
	logic [23:0] s_tdata = '0;
	// operation
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// cluster[2:0], membership[19:3], squared_distance[56:20], zero fill
	logic [63:0] m_tdata;
	logic        m_tlast;

	fuzzy_cmeans_membership dut (.*);

	// predictor state
	logic signed [15:0] cent_tbl [NCL*NDIM];
	u64_t               dist_acc [NCL];
	int unsigned        clust_reg = 2, dim_reg = 1, expo_reg = 4096;
	u64_t               exp_tab [17];

	fcm_item_t pend_items [$];
	memb_res_t memb_q [$];
	fcm_item_t cur_item;
	int        err_cnt = 0;
	int        idle_cnt = 0;
	int        burst_left = 8, gap_left = 0;
	int        stall_mode = 0, stall_cnt = 0;

	initial forever #1 clk = ~clk;

	function automatic u64_t int_sqrt(u64_t xin);
		u64_t x, r, b;
		x = xin;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint log2_fix(u64_t x);
		int p;
		u64_t m, frac;
		p = 63;
		frac = 0;
		while (p > 0 && x[p] == 1'b0) p--;
		m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (Q30_ONE << 1)) begin
				m >>= 1;
				frac |= 64'd1 << i;
			end
		end
		return longint'((u64_t'(p) << 16) | frac);
	endfunction

	function automatic u64_t exp2_fix(longint y);
		longint ip, s;
		u64_t f, r;
		ip = y >>> 16;
		f = u64_t'(y - ip * 65536);
		r = Q30_ONE;
		for (int j = 1; j <= 16; j++)
			if (f[16-j]) r = (r * exp_tab[j]) >> 30;
		if (ip > 16) return TERM_SAT;
		if (ip >= 14) begin
			r <<= (ip - 14);
		end else begin
			s = 14 - ip;
			if (s >= 63) return 0;
			r >>= s;
		end
		return (r > TERM_SAT) ? TERM_SAT : r;
	endfunction

	task automatic apply_item(fcm_item_t it);
		int unsigned kc;
		longint d, lk, p, y;
		u64_t ad, sq, dk, dk2, term, sum, mem;
		memb_res_t res;
		kc = (clust_reg == 0) ? 1 : ((clust_reg > NCL) ? NCL : clust_reg);
		if (it.op == OP_CENTROID) begin
			cent_tbl[it.ci*NDIM + it.fi] = it.val;
			return;
		end
		if (it.fi < dim_reg) begin
			for (int k = 0; k < kc; k++) begin
				d = longint'(it.val) - longint'(cent_tbl[k*NDIM + it.fi]);
				ad = (d < 0) ? u64_t'(-d) : u64_t'(d);
				sq = ad * ad;
				dist_acc[k] = (sq > fcm_pkg::DIST_MAX - dist_acc[k]) ?
					fcm_pkg::DIST_MAX : dist_acc[k] + sq;
			end
		end
		if (!it.last) return;
		for (int k = 0; k < kc; k++) begin
			dk = dist_acc[k];
			sum = 0;
			lk = (dk != 0) ? log2_fix(dk) : 0;
			for (int k2 = 0; k2 < kc; k2++) begin
				dk2 = dist_acc[k2];
				if (dk2 == 0) term = 0;
				else if (dk == 0) term = (expo_reg == 0) ? 65536 : 0;
				else begin
					p = (lk - log2_fix(dk2)) * longint'(expo_reg);
					y = p >>> 12;
					term = exp2_fix(y);
				end
				sum += term;
			end
			if (sum == 0) mem = 0;
			else begin
				mem = (64'd1 << 32) / sum;
				if (mem > 65536) mem = 65536;
			end
			res.cl = k[2:0];
			res.memb = mem[16:0];
			res.sqd = dk[36:0];
			res.last = (k + 1 == kc);
			memb_q.push_back(res);
		end
		for (int k = 0; k < NCL; k++) dist_acc[k] = 0;
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		fcm_item_t it;
		logic nv;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) apply_item(cur_item);
			if (!(s_tvalid && !s_tready)) begin
				nv = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pend_items.size() > 0) begin
					it = pend_items.pop_front();
					cur_item = it;
					nv = 1'b1;
					s_tuser <= it.op;
					s_tlast <= it.last;
					s_tdata <= {1'b0, it.val, it.fi, it.ci};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
				s_tvalid <= nv;
			end
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk or negedge arst_n) begin
		memb_res_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			stall_cnt++;
			if (stall_cnt >= 64) begin
				stall_cnt = 0;
				stall_mode = $urandom_range(0, 3);
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (stall_cnt[2:0] != 3'd0);
			endcase
			if (m_tvalid && m_tready) begin
				if (memb_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h last %b",
						$time, m_tdata, m_tlast);
					err_cnt++;
				end else begin
					e = memb_q.pop_front();
					if (m_tdata[2:0] !== e.cl) begin
						$display("%0t: cluster expected %0d actual %0d", $time, e.cl, m_tdata[2:0]);
						err_cnt++;
					end
					if (m_tdata[19:3] !== e.memb) begin
						$display("%0t: membership expected %0d actual %0d",
							$time, e.memb, m_tdata[19:3]);
						err_cnt++;
					end
					if (m_tdata[56:20] !== e.sqd) begin
						$display("%0t: distance expected %0d actual %0d",
							$time, e.sqd, m_tdata[56:20]);
						err_cnt++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
						err_cnt++;
					end
				end
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
				idle_cnt = 0;
			end else begin
				idle_cnt++;
				if (idle_cnt >= IDLE_LIMIT) begin
					$display("fuzzy_cmeans_membership_tb failed");
					$finish;
				end
			end
		end
	end

	function automatic fcm_item_t mk_item(logic op, int ci, int fi, int val, logic last);
		fcm_item_t it;
		it.op = op;
		it.ci = ci[2:0];
		it.fi = fi[3:0];
		it.val = val[15:0];
		it.last = last;
		return it;
	endfunction

	task automatic wr_reg(logic [1:0] idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[15:0];
		case (idx)
			fcm_pkg::REG_CLUSTER_COUNT: clust_reg = v & 4'hF;
			fcm_pkg::REG_DIM_COUNT:     dim_reg = v & 5'h1F;
			fcm_pkg::REG_EXPONENT:      expo_reg = v & 16'hFFFF;
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		while (pend_items.size() != 0 || s_tvalid || memb_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// one point: in-range features with random content, some noise
	task automatic queue_point();
		int nf, v, sel, cl;
		nf = (dim_reg > NDIM) ? NDIM : dim_reg;
		if (nf > 1 && $urandom_range(0, 9) == 0) nf = $urandom_range(1, nf - 1);
		if (nf == 0) nf = 1;
		for (int f = 0; f < nf; f++) begin
			sel = $urandom_range(0, 3);
			cl = $urandom_range(0, NCL - 1);
			case (sel)
				0: v = int'(cent_tbl[cl*NDIM + f]);
				1: v = $urandom_range(0, 64) - 32;
				default: v = $urandom;
			endcase
			if ($urandom_range(0, 7) == 0)
				pend_items.push_back(mk_item(OP_CENTROID, $urandom_range(0, 7),
					$urandom_range(0, 15), $urandom, $urandom_range(0, 1)));
			if (dim_reg < NDIM && $urandom_range(0, 7) == 0)
				pend_items.push_back(mk_item(OP_FEATURE, $urandom, $urandom_range(dim_reg, 15),
					$urandom, 1'b0));
			pend_items.push_back(mk_item(OP_FEATURE, $urandom, f, v, f == nf - 1));
		end
	endtask

	initial begin
		int n;
		int unsigned cc, dc, ex;
		u64_t c;
		c = 64'd1 << 31;
		for (int j = 1; j <= 16; j++) begin
			c = int_sqrt(c << 30);
			exp_tab[j] = c;
		end
		for (int i = 0; i < NCL*NDIM; i++) cent_tbl[i] = '0;
		for (int k = 0; k < NCL; k++) dist_acc[k] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// fill the whole table: cluster 0 zeros, cluster 1 extremes
		for (int k = 0; k < NCL; k++)
			for (int f = 0; f < NDIM; f++)
				pend_items.push_back(mk_item(OP_CENTROID, k, f,
					(k == 0) ? 0 : (k == 1) ? ((f % 2) ? -32768 : 32767) : int'($urandom),
					$urandom_range(0, 1)));

		// directed, reset settings: two clusters, one feature
		pend_items.push_back(mk_item(OP_FEATURE, 0, 0, 0, 1'b1));       // zero distance
		pend_items.push_back(mk_item(OP_FEATURE, 7, 0, 32767, 1'b1));
		pend_items.push_back(mk_item(OP_FEATURE, 0, 0, -32768, 1'b1));
		pend_items.push_back(mk_item(OP_FEATURE, 0, 0, 123, 1'b0));
		pend_items.push_back(mk_item(OP_FEATURE, 0, 5, 999, 1'b1));      // beyond dim_count
		pend_items.push_back(mk_item(OP_FEATURE, 0, 15, -5, 1'b1));      // all distances zero
		pend_items.push_back(mk_item(OP_CENTROID, 1, 0, 32767, 1'b1));   // no result
		pend_items.push_back(mk_item(OP_FEATURE, 0, 0, -32768, 1'b1));
		pend_items.push_back(mk_item(OP_FEATURE, 5, 0, 32767, 1'b1));
		wait_idle();

		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin cc = 8; dc = 16; ex = 65535; end
				1: begin cc = 1; dc = 1; ex = 256; end
				2: begin cc = 0; dc = 31; ex = 0; end
				3: begin cc = 15; dc = 0; ex = 1; end
				4: begin cc = 8; dc = 3; ex = 0; end
				default: begin
					cc = $urandom_range(1, 8);
					dc = $urandom_range(1, 16);
					ex = $urandom_range(256, 65535);
				end
			endcase
			wr_reg(fcm_pkg::REG_CLUSTER_COUNT, cc);
			wr_reg(fcm_pkg::REG_DIM_COUNT, dc);
			wr_reg(fcm_pkg::REG_EXPONENT, ex);
			@(posedge clk);
			cfg_we <= 1'b0;
			n = 0;
			while (n < 36) begin
				queue_point();
				n = pend_items.size();
			end
			wait_idle();
		end

		while (pend_items.size() != 0 || s_tvalid || memb_q.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (err_cnt == 0 && memb_q.size() == 0)
			$display("fuzzy_cmeans_membership_tb passed");
		else
			$display("fuzzy_cmeans_membership_tb failed");
		$finish;
	end

endmodule
